@@ rtl/pldb_pkg.sv @@
// ----------------------------------------------------------------------------
// pldb_pkg
// Shared types and codes for the price level depth book.
// ----------------------------------------------------------------------------
package pldb_pkg;

  // Fixed field widths of one operation word and one result word
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned QTY_W    = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LCOUNT_W = 4;

  // Operation codes; codes 5 to 7 are no-ops
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD      = 3'd0,
    FUNC_UPDATE   = 3'd1,
    FUNC_DELETE   = 3'd2,
    FUNC_DEL_FROM = 3'd3,
    FUNC_CLEAR    = 3'd4
  } func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_BAD_LVL  = 2'd1,
    ST_MISMATCH = 2'd2
  } status_e;

  typedef logic signed [PRICE_W-1:0] price_t;
  typedef logic        [QTY_W-1:0]   qty_t;

endpackage

@@ rtl/pldb_op_if.sv @@
// ----------------------------------------------------------------------------
// pldb_op_if
// Operation channel: valid/ready handshake with one book operation per word.
// ----------------------------------------------------------------------------
interface pldb_op_if import pldb_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [LEVEL_W-1:0] level;
  price_t             price;
  qty_t               quantity;

  modport source (output valid, output func, output level, output price,
                  output quantity, input ready);
  modport sink   (input valid, input func, input level, input price,
                  input quantity, output ready);

endinterface

@@ rtl/pldb_res_if.sv @@
// ----------------------------------------------------------------------------
// pldb_res_if
// Result channel: valid/ready handshake with status and top of book per word.
// ----------------------------------------------------------------------------
interface pldb_res_if import pldb_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LCOUNT_W-1:0] level_count;
  price_t              best_price;
  qty_t                best_quantity;

  modport source (output valid, output status, output level_count,
                  output best_price, output best_quantity, input ready);
  modport sink   (input valid, input status, input level_count,
                  input best_price, input best_quantity, output ready);

endinterface

@@ rtl/pldb_apply.sv @@
// ----------------------------------------------------------------------------
// pldb_apply
// Next-state logic of the book: applies one operation to the level array.
// ----------------------------------------------------------------------------
module pldb_apply import pldb_pkg::*; #(
  parameter int unsigned DEPTH = 10,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic [CNT_W-1:0]   count_i,
  input  price_t             price_i [DEPTH],
  input  qty_t               qty_i   [DEPTH],
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [LEVEL_W-1:0] level_i,
  input  price_t             op_price_i,
  input  qty_t               op_qty_i,
  output logic [CNT_W-1:0]   count_o,
  output price_t             price_o [DEPTH],
  output qty_t               qty_o   [DEPTH],
  output status_e            status_o
);

  localparam int unsigned CMP_W = LEVEL_W + 1;

  logic [CMP_W-1:0]   lvl_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic [LEVEL_W-1:0] pos;
  logic               lvl_ok;
  logic               lvl_ok_add;
  logic               price_hit;
  price_t             sel_price;

  // Range checks against the current fill
  assign lvl_ext    = {1'b0, level_i};
  assign cnt_ext    = CMP_W'(count_i);
  assign pos        = level_i - LEVEL_W'(1);
  assign lvl_ok     = (level_i != '0) && (lvl_ext <= cnt_ext);
  assign lvl_ok_add = (level_i != '0) && (lvl_ext <= cnt_ext + CMP_W'(1));

  // Stored price at the addressed level
  always_comb begin
    sel_price = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos == LEVEL_W'(i)) sel_price = sel_price | price_i[i];
    end
  end
  assign price_hit = (sel_price == op_price_i);

  always_comb begin
    count_o  = count_i;
    price_o  = price_i;
    qty_o    = qty_i;
    status_o = ST_DONE;
    case (func_e'(func_i))
      FUNC_ADD: begin
        if (!lvl_ok_add) begin
          status_o = ST_BAD_LVL;
        end else begin
          // insert at pos, push deeper levels down; last one falls off
          for (int i = 0; i < DEPTH; i++) begin
            if (pos == LEVEL_W'(i)) begin
              price_o[i] = op_price_i;
              qty_o[i]   = op_qty_i;
            end else if (i > 0 && LEVEL_W'(i) > pos) begin
              price_o[i] = price_i[(i > 0) ? i - 1 : 0];
              qty_o[i]   = qty_i[(i > 0) ? i - 1 : 0];
            end
          end
          if (count_i < CNT_W'(DEPTH)) count_o = count_i + CNT_W'(1);
        end
      end
      FUNC_UPDATE: begin
        if (!lvl_ok) begin
          status_o = ST_BAD_LVL;
        end else if (!price_hit) begin
          status_o = ST_MISMATCH;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (pos == LEVEL_W'(i)) qty_o[i] = op_qty_i;
          end
        end
      end
      FUNC_DELETE: begin
        if (!lvl_ok) begin
          status_o = ST_BAD_LVL;
        end else if (!price_hit) begin
          status_o = ST_MISMATCH;
        end else begin
          // pull deeper levels up over the removed one
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (LEVEL_W'(i) >= pos) begin
              price_o[i] = price_i[i + 1];
              qty_o[i]   = qty_i[i + 1];
            end
          end
          count_o = count_i - CNT_W'(1);
        end
      end
      FUNC_DEL_FROM: begin
        if (!lvl_ok) status_o = ST_BAD_LVL;
        else         count_o  = CNT_W'(pos);
      end
      FUNC_CLEAR: begin
        count_o = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/price_level_depth_book.sv @@
// ----------------------------------------------------------------------------
// price_level_depth_book
// One side of a market-by-price book with up to DEPTH levels.
// ----------------------------------------------------------------------------
// Takes one operation word per clock (add, update, delete, delete-from,
// clear) and returns one result word per operation, carrying the status and
// the level count, best price and best quantity after the operation. The
// level array sits in flip-flops and is rewritten in the cycle the word is
// accepted, so throughput is one operation per cycle unless the result
// stalls, and the result appears in the cycle after acceptance. A new word
// gets into the single result register whenever the held result is taken or
// it is empty; a stalled result holds ready low. Level count is reported in 4 bits.
module price_level_depth_book import pldb_pkg::*; #(
  parameter int unsigned DEPTH = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pldb_op_if.sink    op_i,
  pldb_res_if.source res_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Book storage
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  price_t           price_q [DEPTH];
  price_t           price_d [DEPTH];
  qty_t             qty_q   [DEPTH];
  qty_t             qty_d   [DEPTH];
  status_e          status_d;

  // Result register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [LCOUNT_W-1:0] out_count_q;
  price_t              out_price_q;
  qty_t                out_qty_q;

  logic accept;

  assign op_i.ready = !out_valid_q || res_o.ready;
  assign accept     = op_i.valid && op_i.ready;

  pldb_apply #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_apply (
    .count_i    (count_q),
    .price_i    (price_q),
    .qty_i      (qty_q),
    .func_i     (op_i.func),
    .level_i    (op_i.level),
    .op_price_i (op_i.price),
    .op_qty_i   (op_i.quantity),
    .count_o    (count_d),
    .price_o    (price_d),
    .qty_o      (qty_d),
    .status_o   (status_d)
  );

  // Control: fill count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) count_q <= count_d;
      if (accept)           out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Payload: level array and result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      price_q      <= price_d;
      qty_q        <= qty_d;
      out_status_q <= status_d;
      out_count_q  <= LCOUNT_W'(count_d);
      out_price_q  <= (count_d != '0) ? price_d[0] : '0;
      out_qty_q    <= (count_d != '0) ? qty_d[0] : '0;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.status        = out_status_q;
  assign res_o.level_count   = out_count_q;
  assign res_o.best_price    = out_price_q;
  assign res_o.best_quantity = out_qty_q;

endmodule

@@ rtl/pldb_checker.sv @@
// ----------------------------------------------------------------------------
// pldb_checker
// Port-level assertions for the price level depth book, bound to the top.
// ----------------------------------------------------------------------------
module pldb_checker import pldb_pkg::*; #(
  parameter int unsigned DEPTH = 10
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid,
  input logic                in_ready,
  input logic [FUNC_W-1:0]   in_func,
  input logic [LEVEL_W-1:0]  in_level,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [LCOUNT_W-1:0] out_count,
  input price_t              out_price,
  input qty_t                out_qty
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled result word holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count)
      && $stable(out_price) && $stable(out_qty))
    else $error("result word changed while stalled");

  // Every accepted word yields a result on the next cycle
  a_res_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid)
    else $error("no result after accepted operation");

  // Clear empties the book
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_func == FUNC_CLEAR |=> out_count == '0 && out_price == '0
      && out_qty == '0 && out_status == ST_DONE)
    else $error("clear did not empty the book");

  // Level zero is never in range for addressed operations
  a_lvl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_level == '0 && (in_func == FUNC_ADD || in_func == FUNC_UPDATE
      || in_func == FUNC_DELETE || in_func == FUNC_DEL_FROM)
      |=> out_status == ST_BAD_LVL)
    else $error("level zero not reported out of range");

  // An empty book reports zero top of book
  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DEPTH < 16 && out_valid && out_count == '0 |-> out_price == '0 && out_qty == '0)
    else $error("empty book shows a top level");

endmodule

bind price_level_depth_book pldb_checker #(
  .DEPTH (DEPTH)
) u_pldb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (op_i.valid),
  .in_ready   (op_i.ready),
  .in_func    (op_i.func),
  .in_level   (op_i.level),
  .out_valid  (res_o.valid),
  .out_ready  (res_o.ready),
  .out_status (res_o.status),
  .out_count  (res_o.level_count),
  .out_price  (res_o.best_price),
  .out_qty    (res_o.best_quantity)
);
